>>> design/isfb_pkg.sv
// ----------------------------------------------------------------------------
// isfb_pkg
// Shared types, constants and the frame byte layout function for the IMU
// sample frame builder.
// ----------------------------------------------------------------------------
package isfb_pkg;

   localparam int FRAME_LEN    = 32;
   localparam int BYTE_IDX_W   = $clog2(FRAME_LEN);
   localparam int SENSOR_WORDS = 6;
   localparam int WORD_W       = 32;
   localparam int TEMP_W       = 16;
   localparam int COUNTER_W    = 16;
   localparam int SUM_FIRST    = 2;
   localparam int SUM_COUNT    = 29;
   localparam int SUM_LAST     = SUM_FIRST + SUM_COUNT - 1;
   localparam int WORD_BASE    = 5;
   localparam int TEMP_BASE    = WORD_BASE + 4 * SENSOR_WORDS;

   localparam logic [7:0] HEADER_0   = 8'h55;
   localparam logic [7:0] HEADER_1   = 8'hAA;
   localparam logic [7:0] FRAME_TYPE = 8'h01;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_IDX_W-1:0] IDX_LAST      = BYTE_IDX_W'(FRAME_LEN - 1);
   localparam logic [BYTE_IDX_W-1:0] IDX_SUM_FIRST = BYTE_IDX_W'(SUM_FIRST);
   localparam logic [BYTE_IDX_W-1:0] IDX_SUM_LAST  = BYTE_IDX_W'(SUM_LAST);

   typedef struct packed {
      logic [COUNTER_W-1:0]                counter;
      logic [TEMP_W-1:0]                   temperature;
      logic [SENSOR_WORDS-1:0][WORD_W-1:0] words;
   } sample_record_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [7:0] frame_byte_at(
      input sample_record_type       rec,
      input logic [BYTE_IDX_W-1:0]   idx,
      input logic [7:0]              sum
   );
      logic [FRAME_LEN-1:0][7:0] f;
      f[0] = HEADER_0;
      f[1] = HEADER_1;
      f[2] = FRAME_TYPE;
      f[3] = rec.counter[7:0];
      f[4] = rec.counter[15:8];
      for (int k = 0; k < SENSOR_WORDS; k++) begin
         for (int j = 0; j < 4; j++) begin
            f[WORD_BASE + 4 * k + j] = rec.words[k][8 * j +: 8];
         end
      end
      f[TEMP_BASE]     = rec.temperature[7:0];
      f[TEMP_BASE + 1] = rec.temperature[15:8];
      f[FRAME_LEN - 1] = sum;
      return f[idx];
   endfunction

endpackage

>>> design/isfb_front.sv
// ----------------------------------------------------------------------------
// isfb_front
// Accepts sample sets, stamps each with the frame counter and pushes the
// record into the frame queue.
// ----------------------------------------------------------------------------
module isfb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [31:0]                  req_gyro_x_bits,
   input  logic [31:0]                  req_gyro_y_bits,
   input  logic [31:0]                  req_gyro_z_bits,
   input  logic [31:0]                  req_accel_x_bits,
   input  logic [31:0]                  req_accel_y_bits,
   input  logic [31:0]                  req_accel_z_bits,
   input  logic signed [15:0]           req_temperature,
   input  isfb_pkg::queue_status_type   q_status,
   output logic                         q_push,
   output isfb_pkg::sample_record_type  q_wr_rec
);
   import isfb_pkg::*;

   logic [COUNTER_W-1:0] counter_ff;
   logic [COUNTER_W-1:0] counter_in;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   always_comb begin
      q_wr_rec.counter     = counter_ff;
      q_wr_rec.temperature = req_temperature;
      q_wr_rec.words[0]    = req_gyro_x_bits;
      q_wr_rec.words[1]    = req_gyro_y_bits;
      q_wr_rec.words[2]    = req_gyro_z_bits;
      q_wr_rec.words[3]    = req_accel_x_bits;
      q_wr_rec.words[4]    = req_accel_y_bits;
      q_wr_rec.words[5]    = req_accel_z_bits;
   end

   assign counter_in = q_push ? counter_ff + COUNTER_W'(1) : counter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else begin
         counter_ff <= counter_in;
      end
   end

endmodule

>>> design/isfb_queue.sv
// ----------------------------------------------------------------------------
// isfb_queue
// Short record queue between the accept side and the serializer.
// ----------------------------------------------------------------------------
module isfb_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_push,
   input  isfb_pkg::sample_record_type  q_wr_rec,
   input  logic                         q_pop,
   output isfb_pkg::sample_record_type  q_rd_rec,
   output isfb_pkg::queue_status_type   q_status
);
   import isfb_pkg::*;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   sample_record_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign q_status.full      = (count_ff == CNT_FULL);
   assign q_status.not_empty = (count_ff != '0);
   assign q_rd_rec           = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      case ({q_push, q_pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ptr_ff] <= q_wr_rec;
      end
   end

endmodule

>>> design/isfb_back.sv
// ----------------------------------------------------------------------------
// isfb_back
// Frame serializer: walks the head record byte by byte, accumulates the
// checksum and drives the registered result channel.
// ----------------------------------------------------------------------------
module isfb_back (
   input  logic                         clock,
   input  logic                         reset,
   input  isfb_pkg::sample_record_type  q_rd_rec,
   input  isfb_pkg::queue_status_type   q_status,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_frame_byte,
   output logic                         rsp_last_byte
);
   import isfb_pkg::*;

   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]            sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_frame_byte_ff, rsp_frame_byte_in;
   logic                  rsp_last_byte_ff, rsp_last_byte_in;
   logic                  advance;
   logic                  emit;
   logic [7:0]            cur_byte;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign emit     = advance && q_status.not_empty;
   assign q_pop    = emit && (idx_ff == IDX_LAST);
   assign cur_byte = frame_byte_at(q_rd_rec, idx_ff, sum_ff);

   always_comb begin
      idx_in            = idx_ff;
      sum_in            = sum_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_frame_byte_in = rsp_frame_byte_ff;
      rsp_last_byte_in  = rsp_last_byte_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_frame_byte_in = cur_byte;
         rsp_last_byte_in  = (idx_ff == IDX_LAST);
         if (idx_ff == IDX_LAST) begin
            idx_in = '0;
            sum_in = '0;
         end else begin
            idx_in = idx_ff + BYTE_IDX_W'(1);
            if (idx_ff >= IDX_SUM_FIRST && idx_ff <= IDX_SUM_LAST) begin
               sum_in = sum_ff + cur_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_byte_ff <= rsp_frame_byte_in;
      rsp_last_byte_ff  <= rsp_last_byte_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_last_byte  = rsp_last_byte_ff;

endmodule

>>> design/imu_sample_frame_builder.sv
// ----------------------------------------------------------------------------
// imu_sample_frame_builder
// Turns each IMU sample set into a 32-byte serial frame with header, counter,
// sensor words, temperature and additive checksum.
// ----------------------------------------------------------------------------
// The input record is registered in the queue, then the first frame byte in
// the result register. The byte serializer emits one frame byte per cycle
// while rsp_stall is low; a two-entry queue lets input transfers overlap.
// Reset: synchronous; clears frame counter to 0, empties the queue and
// drops the result valid.
// ----------------------------------------------------------------------------
module imu_sample_frame_builder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_gyro_x_bits,
   input  logic [31:0]        req_gyro_y_bits,
   input  logic [31:0]        req_gyro_z_bits,
   input  logic [31:0]        req_accel_x_bits,
   input  logic [31:0]        req_accel_y_bits,
   input  logic [31:0]        req_accel_z_bits,
   input  logic signed [15:0] req_temperature,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte
);
   import isfb_pkg::*;

   queue_status_type  q_status;
   logic              q_push;
   logic              q_pop;
   sample_record_type q_wr_rec;
   sample_record_type q_rd_rec;

   isfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_gyro_x_bits  (req_gyro_x_bits),
      .req_gyro_y_bits  (req_gyro_y_bits),
      .req_gyro_z_bits  (req_gyro_z_bits),
      .req_accel_x_bits (req_accel_x_bits),
      .req_accel_y_bits (req_accel_y_bits),
      .req_accel_z_bits (req_accel_z_bits),
      .req_temperature  (req_temperature),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_wr_rec         (q_wr_rec)
   );

   isfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_wr_rec (q_wr_rec),
      .q_pop    (q_pop),
      .q_rd_rec (q_rd_rec),
      .q_status (q_status)
   );

   isfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_rd_rec       (q_rd_rec),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

>>> design/isfb_checker.sv
// ----------------------------------------------------------------------------
// isfb_checker
// Port-level checks on the frame output: hold under stall, header bytes and
// end-of-frame marker position.
// ----------------------------------------------------------------------------
module isfb_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_frame_byte,
   input  logic       rsp_last_byte
);
   import isfb_pkg::*;

   logic [BYTE_IDX_W-1:0] pos_ff, pos_in;
   logic                  xfer;

   assign xfer   = rsp_valid && !rsp_stall;
   assign pos_in = xfer ? pos_ff + BYTE_IDX_W'(1) : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
                                 && $stable(rsp_last_byte))
      else $error("result changed while stalled");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_byte == (pos_ff == IDX_LAST)))
      else $error("end-of-frame marker out of place");

   a_hdr0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pos_ff == '0 |-> rsp_frame_byte == HEADER_0)
      else $error("bad first header byte");

   a_hdr_rest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pos_ff == BYTE_IDX_W'(1) |-> rsp_frame_byte == HEADER_1)
      else $error("bad second header byte");

   a_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pos_ff == BYTE_IDX_W'(2) |-> rsp_frame_byte == FRAME_TYPE)
      else $error("bad frame type byte");

endmodule

bind imu_sample_frame_builder isfb_checker u_isfb_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_frame_byte (rsp_frame_byte),
   .rsp_last_byte  (rsp_last_byte)
);
